// File: rtl/hmti_pkg.sv
// ----------------------------------------------------------------------------
// hmti_pkg: shared constants and types for the height grid core
// widths, operation codes and the memory request bundle
// ----------------------------------------------------------------------------
package hmti_pkg;

    localparam int MAX_DIM   = 257;
    localparam int MIN_DIM   = 2;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int H_W       = 24;                // q15.8 height
    localparam int C_W       = 18;                // q10.8 coordinate
    localparam int FR_W      = 8;                 // fraction bits
    localparam int IX_W      = C_W - FR_W;        // integer part of a coordinate
    localparam int S_W       = 9;                 // grid size register
    localparam int CNT_W     = $clog2(IX_W + 1);
    localparam int W_W       = FR_W + 1;          // weight, up to 1.0
    localparam int D_W       = H_W + 1;           // height difference
    localparam int P_W       = D_W + W_W + 1;     // signed product
    localparam int ACC_W     = P_W + 1;

    localparam int MODE_W       = 2;
    localparam int IN_TDATA_W   = ((2 * C_W + H_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((3 * H_W + 7) / 8) * 8;
    localparam int X_LSB        = 0;
    localparam int Y_LSB        = C_W;
    localparam int H_LSB        = 2 * C_W;

    localparam logic [S_W-1:0] SIZE_RESET = S_W'(MAX_DIM);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE  = 2'd0,
        MODE_POINT  = 2'd1,
        MODE_INTERP = 2'd2
    } t_mode;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [H_W-1:0]    wdata;
    } t_mem_req;

endpackage

// File: rtl/hmti_mod.sv
// ----------------------------------------------------------------------------
// hmti_mod: iterative remainder unit
// restoring remainder of a grid coordinate by the grid size, one bit a cycle
// ----------------------------------------------------------------------------
module hmti_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hmti_pkg::IX_W-1:0]  i_num,
    input  logic [hmti_pkg::S_W-1:0]   i_den,
    output logic                       o_done,
    output logic [hmti_pkg::S_W-1:0]   o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [hmti_pkg::CNT_W-1:0]  r_cnt;
    logic [hmti_pkg::IX_W-1:0]   r_num;
    logic [hmti_pkg::S_W-1:0]    r_rem;
    logic [hmti_pkg::S_W-1:0]    r_den;

    logic [hmti_pkg::S_W:0]      trial;
    logic [hmti_pkg::S_W:0]      diff;
    logic [hmti_pkg::S_W-1:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_num[hmti_pkg::IX_W-1]};
        diff  = trial - {1'b0, r_den};
        if (trial >= {1'b0, r_den}) begin
            n_rem = diff[hmti_pkg::S_W-1:0];
        end else begin
            n_rem = trial[hmti_pkg::S_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hmti_pkg::CNT_W'(hmti_pkg::IX_W);
                r_num  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[hmti_pkg::IX_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == hmti_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/hmti_store.sv
// ----------------------------------------------------------------------------
// hmti_store: height memory
// single port memory with registered read and a zeroing sweep after reset
// ----------------------------------------------------------------------------
module hmti_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hmti_pkg::t_mem_req        i_req,
    output logic [hmti_pkg::H_W-1:0]  o_rdata,
    output logic                      o_ready
);

    logic [hmti_pkg::H_W-1:0]    mem [hmti_pkg::DEPTH];
    logic [hmti_pkg::H_W-1:0]    r_rdata;
    logic                        r_clr_busy;
    logic [hmti_pkg::ADDR_W-1:0] r_clr_addr;

    logic                        wr_en;
    logic [hmti_pkg::ADDR_W-1:0] wr_addr;
    logic [hmti_pkg::H_W-1:0]    wr_data;

    // sweep owns the write port until every entry is zero
    always_comb begin
        wr_en   = r_clr_busy | i_req.we;
        wr_addr = r_clr_busy ? r_clr_addr : i_req.addr;
        wr_data = r_clr_busy ? '0 : i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == hmti_pkg::ADDR_W'(hmti_pkg::DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clr_busy;

endmodule

// File: rtl/hmti_blend.sv
// ----------------------------------------------------------------------------
// hmti_blend: triangle plane evaluation
// base*256 + w1*d1 + w2*d2 through one shared multiplier, floor by 256
// ----------------------------------------------------------------------------
module hmti_blend (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [hmti_pkg::H_W-1:0]   i_base,
    input  logic signed [hmti_pkg::D_W-1:0]   i_d1,
    input  logic signed [hmti_pkg::D_W-1:0]   i_d2,
    input  logic [hmti_pkg::W_W-1:0]          i_w1,
    input  logic [hmti_pkg::W_W-1:0]          i_w2,
    output logic                              o_done,
    output logic [hmti_pkg::H_W-1:0]          o_res
);

    localparam int Q_W = hmti_pkg::ACC_W - hmti_pkg::FR_W;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_SUM,
        B_DONE
    } t_bstate;

    t_bstate                             r_state;
    logic signed [hmti_pkg::H_W-1:0]     r_base;
    logic signed [hmti_pkg::D_W-1:0]     r_d1;
    logic signed [hmti_pkg::D_W-1:0]     r_d2;
    logic [hmti_pkg::W_W-1:0]            r_w1;
    logic [hmti_pkg::W_W-1:0]            r_w2;
    logic signed [hmti_pkg::P_W-1:0]     r_p1;
    logic signed [hmti_pkg::P_W-1:0]     r_p2;
    logic signed [hmti_pkg::ACC_W-1:0]   r_acc;

    logic signed [hmti_pkg::D_W-1:0]     mul_d;
    logic signed [hmti_pkg::W_W:0]       mul_w;
    logic signed [hmti_pkg::P_W-1:0]     prod;
    logic signed [hmti_pkg::ACC_W-1:0]   base_sh;
    logic [Q_W-1:0]                      quot;
    logic                                fits;

    always_comb begin
        mul_d   = (r_state == B_MUL1) ? r_d1 : r_d2;
        mul_w   = (r_state == B_MUL1) ? $signed({1'b0, r_w1}) : $signed({1'b0, r_w2});
        prod    = mul_d * mul_w;
        base_sh = hmti_pkg::ACC_W'(r_base) <<< hmti_pkg::FR_W;
        // arithmetic shift right by 8 is the floor division
        quot    = r_acc[hmti_pkg::ACC_W-1:hmti_pkg::FR_W];
        fits    = (&quot[Q_W-1:hmti_pkg::H_W-1]) | ~(|quot[Q_W-1:hmti_pkg::H_W-1]);
        if (fits) begin
            o_res = quot[hmti_pkg::H_W-1:0];
        end else if (quot[Q_W-1]) begin
            o_res = {1'b1, {(hmti_pkg::H_W-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(hmti_pkg::H_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_base  <= i_base;
                        r_d1    <= i_d1;
                        r_d2    <= i_d2;
                        r_w1    <= i_w1;
                        r_w2    <= i_w2;
                        r_state <= B_MUL1;
                    end
                end
                B_MUL1: begin
                    r_p1    <= prod;
                    r_state <= B_MUL2;
                end
                B_MUL2: begin
                    r_p2    <= prod;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_acc   <= base_sh + hmti_pkg::ACC_W'(r_p1) + hmti_pkg::ACC_W'(r_p2);
                    r_state <= B_DONE;
                end
                B_DONE: begin
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == B_DONE);

endmodule

// File: rtl/heightmap_store_with_triangle_interp_core.sv
// ----------------------------------------------------------------------------
// heightmap_store_with_triangle_interp_core: height grid with triangle read
// square grid of q15.8 heights with write, wrapped point read and
// diagonal-split interpolated read
// ----------------------------------------------------------------------------
// The block keeps a square grid of signed q15.8 heights, grid_size points
// per side (clamped to 2..257), in one single-port memory of 257*257 words
// with a registered read. After reset a zeroing sweep walks the whole memory,
// one entry a cycle, and no transaction is taken meanwhile; the size register
// can be written at any time the core is idle. Each input transaction gives
// exactly one output transaction. Each coordinate goes through its own
// iterative remainder unit (one bit a cycle) so that reads wrap modulo the
// grid size, then a row multiply forms the address. An interpolated read
// takes longer than a write or a point read because it issues three memory
// reads back to back on the single port and then runs the plane evaluation
// through one shared multiplier. A finished result sits in an output
// register, so the next transaction is taken while the previous result still
// waits for the downstream side.
// ----------------------------------------------------------------------------
module heightmap_store_with_triangle_interp_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input: x_coord [17:0], y_coord [35:18], height_in [59:36], zero fill
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [hmti_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // input: mode [1:0]
    input  logic [hmti_pkg::MODE_W-1:0]           s_axis_tuser,
    // output: height_out [23:0], lowest [47:24], highest [71:48]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [hmti_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // output: out_of_range [0]
    output logic [0:0]                            m_axis_tuser,
    // grid size register
    input  logic                                  i_cfg_we,
    input  logic [hmti_pkg::S_W-1:0]              i_cfg_wdata
);

    localparam int H_W    = hmti_pkg::H_W;
    localparam int S_W    = hmti_pkg::S_W;
    localparam int IX_W   = hmti_pkg::IX_W;
    localparam int FR_W   = hmti_pkg::FR_W;
    localparam int ADDR_W = hmti_pkg::ADDR_W;
    localparam int D_W    = hmti_pkg::D_W;
    localparam int W_W    = hmti_pkg::W_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,     // wait for both coordinate remainders
        S_ROW,     // neighbor column and second row base
        S_ACC0,    // write, or first read
        S_ACC1,
        S_ACC2,
        S_ACC3,
        S_BLEND,
        S_BWAIT,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [S_W-1:0]              r_cfg_size;
    logic [hmti_pkg::MODE_W-1:0] r_mode;
    logic [IX_W-1:0]             r_ix;
    logic [IX_W-1:0]             r_iy;
    logic [FR_W-1:0]             r_fx;
    logic [FR_W-1:0]             r_fy;
    logic [H_W-1:0]              r_hin;
    logic                        r_upper;
    logic                        r_oor;
    logic [S_W-1:0]              r_xm;
    logic [S_W-1:0]              r_ym;
    logic [S_W-1:0]              r_x1;
    logic [ADDR_W-1:0]           r_row0;
    logic [ADDR_W-1:0]           r_row1;
    logic [H_W-1:0]              r_h10;
    logic [H_W-1:0]              r_h01;
    logic [H_W-1:0]              r_hc;
    logic [H_W-1:0]              r_hout;
    logic [H_W-1:0]              r_lowest;
    logic [H_W-1:0]              r_highest;
    logic                        r_m_valid;
    logic [hmti_pkg::OUT_TDATA_W-1:0] r_m_tdata;
    logic                        r_m_tuser;

    logic                        s_accept;
    logic [S_W-1:0]              s_use;
    logic                        store_ready;
    logic [H_W-1:0]              rdata;
    hmti_pkg::t_mem_req          mem_req;

    logic                        mod_x_done;
    logic                        mod_y_done;
    logic [S_W-1:0]              mod_x_rem;
    logic [S_W-1:0]              mod_y_rem;
    logic [2*S_W-1:0]            row_prod;
    logic [S_W:0]                xp1;
    logic [S_W:0]                yp1;

    logic [ADDR_W-1:0]           a00;
    logic [ADDR_W-1:0]           a10;
    logic [ADDR_W-1:0]           a01;
    logic [ADDR_W-1:0]           a11;

    logic signed [D_W-1:0]       d_a;
    logic signed [D_W-1:0]       d_b;
    logic signed [D_W-1:0]       bl_d1;
    logic signed [D_W-1:0]       bl_d2;
    logic [W_W-1:0]              bl_w1;
    logic [W_W-1:0]              bl_w2;
    logic                        bl_start;
    logic                        bl_done;
    logic [H_W-1:0]              bl_res;
    logic                        out_load;
    logic [FR_W:0]               frac_sum;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= hmti_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_cfg_size <= i_cfg_wdata;
        end
    end

    // size in use, clamped to the legal range
    always_comb begin
        if (r_cfg_size < S_W'(hmti_pkg::MIN_DIM)) begin
            s_use = S_W'(hmti_pkg::MIN_DIM);
        end else if (r_cfg_size > S_W'(hmti_pkg::MAX_DIM)) begin
            s_use = S_W'(hmti_pkg::MAX_DIM);
        end else begin
            s_use = r_cfg_size;
        end
    end

    // ------------------------------------------------------- input handshake
    // taken only between items and once the zeroing sweep has finished
    assign s_axis_tready = (r_state == S_IDLE) && store_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // fraction sum reaching 1.0 selects the upper triangle
    assign frac_sum = {1'b0, s_axis_tdata[hmti_pkg::X_LSB +: FR_W]}
                    + {1'b0, s_axis_tdata[hmti_pkg::Y_LSB +: FR_W]};

    // ------------------------------------------------------ coordinate wrap
    hmti_mod u_mod_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_num   (s_axis_tdata[hmti_pkg::X_LSB + FR_W +: IX_W]),
        .i_den   (s_use),
        .o_done  (mod_x_done),
        .o_rem   (mod_x_rem)
    );

    hmti_mod u_mod_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_num   (s_axis_tdata[hmti_pkg::Y_LSB + FR_W +: IX_W]),
        .i_den   (s_use),
        .o_done  (mod_y_done),
        .o_rem   (mod_y_rem)
    );

    assign row_prod = mod_y_rem * s_use;
    assign xp1      = {1'b0, r_xm} + 1'b1;
    assign yp1      = {1'b0, r_ym} + 1'b1;

    // corner addresses: point (x, y) lives at x + y * size
    assign a00 = ADDR_W'(r_xm) + r_row0;
    assign a10 = ADDR_W'(r_x1) + r_row0;
    assign a01 = ADDR_W'(r_xm) + r_row1;
    assign a11 = ADDR_W'(r_x1) + r_row1;

    // ---------------------------------------------------------- memory port
    always_comb begin
        mem_req       = '0;
        mem_req.wdata = r_hin;
        case (r_state)
            S_ACC0: begin
                if (r_mode == hmti_pkg::MODE_WRITE) begin
                    mem_req.we   = !r_oor;
                    mem_req.addr = a00;
                end else if (r_mode == hmti_pkg::MODE_POINT) begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = a00;
                end else if (r_mode == hmti_pkg::MODE_INTERP) begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = a10;
                end
            end
            S_ACC1: begin
                mem_req.re   = (r_mode == hmti_pkg::MODE_INTERP);
                mem_req.addr = a01;
            end
            S_ACC2: begin
                // third corner: own corner of the lower or the upper triangle
                mem_req.re   = 1'b1;
                mem_req.addr = r_upper ? a11 : a00;
            end
            default: begin
                mem_req.re = 1'b0;
            end
        endcase
    end

    hmti_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata),
        .o_ready (store_ready)
    );

    // --------------------------------------------------------- plane weights
    // lower: h00 + fx*(h10-h00) + fy*(h01-h00)
    // upper: h11 + (1-fx)*(h01-h11) + (1-fy)*(h10-h11)
    always_comb begin
        d_a = D_W'($signed(r_h10)) - D_W'($signed(r_hc));
        d_b = D_W'($signed(r_h01)) - D_W'($signed(r_hc));
        if (r_upper) begin
            bl_d1 = d_b;
            bl_w1 = W_W'(1 << FR_W) - W_W'(r_fx);
            bl_d2 = d_a;
            bl_w2 = W_W'(1 << FR_W) - W_W'(r_fy);
        end else begin
            bl_d1 = d_a;
            bl_w1 = W_W'(r_fx);
            bl_d2 = d_b;
            bl_w2 = W_W'(r_fy);
        end
    end

    assign bl_start = (r_state == S_BLEND);

    hmti_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bl_start),
        .i_base  ($signed(r_hc)),
        .i_d1    (bl_d1),
        .i_d2    (bl_d2),
        .i_w1    (bl_w1),
        .i_w2    (bl_w2),
        .o_done  (bl_done),
        .o_res   (bl_res)
    );

    // output slot free or being emptied this cycle
    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lowest  <= '0;
            r_highest <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
                r_m_tdata <= {r_highest, r_lowest, r_hout};
                r_m_tuser <= r_oor;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_mode  <= s_axis_tuser;
                        r_ix    <= s_axis_tdata[hmti_pkg::X_LSB + FR_W +: IX_W];
                        r_iy    <= s_axis_tdata[hmti_pkg::Y_LSB + FR_W +: IX_W];
                        r_fx    <= s_axis_tdata[hmti_pkg::X_LSB +: FR_W];
                        r_fy    <= s_axis_tdata[hmti_pkg::Y_LSB +: FR_W];
                        r_hin   <= s_axis_tdata[hmti_pkg::H_LSB +: H_W];
                        r_upper <= frac_sum[FR_W];
                        r_hout  <= '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_x_done && mod_y_done) begin
                        r_xm    <= mod_x_rem;
                        r_ym    <= mod_y_rem;
                        r_row0  <= row_prod[ADDR_W-1:0];
                        // only a write can land outside the grid
                        r_oor   <= (r_mode == hmti_pkg::MODE_WRITE)
                                && ((r_ix >= IX_W'(s_use)) || (r_iy >= IX_W'(s_use)));
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_x1    <= (xp1 == {1'b0, s_use}) ? '0 : xp1[S_W-1:0];
                    r_row1  <= (yp1 == {1'b0, s_use}) ? '0 : r_row0 + ADDR_W'(s_use);
                    r_state <= S_ACC0;
                end
                S_ACC0: begin
                    case (r_mode)
                        hmti_pkg::MODE_WRITE: begin
                            if (!r_oor) begin
                                if ($signed(r_hin) < $signed(r_lowest)) begin
                                    r_lowest <= r_hin;
                                end
                                if ($signed(r_hin) > $signed(r_highest)) begin
                                    r_highest <= r_hin;
                                end
                            end
                            r_state <= S_DONE;
                        end
                        hmti_pkg::MODE_POINT: begin
                            r_state <= S_ACC1;
                        end
                        hmti_pkg::MODE_INTERP: begin
                            r_state <= S_ACC1;
                        end
                        default: begin
                            // unused mode: nothing changes
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_ACC1: begin
                    if (r_mode == hmti_pkg::MODE_POINT) begin
                        r_hout  <= rdata;
                        r_state <= S_DONE;
                    end else begin
                        r_h10   <= rdata;
                        r_state <= S_ACC2;
                    end
                end
                S_ACC2: begin
                    r_h01   <= rdata;
                    r_state <= S_ACC3;
                end
                S_ACC3: begin
                    r_hc    <= rdata;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_state <= S_BWAIT;
                end
                S_BWAIT: begin
                    if (bl_done) begin
                        r_hout  <= bl_res;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // ------------------------------------------------------------ assertions
    // memory writes come from the sequencer only for an in-grid write item
    a_write_only_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_ACC0 && r_mode == hmti_pkg::MODE_WRITE
                        && !r_oor && store_ready))
        else $error("memory write outside an in-grid write item");

    // wrapped coordinates always fall inside the grid
    a_wrap_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_xm < s_use && r_ym < s_use))
        else $error("remainder not below grid size");

    // extremes start at zero, so they bracket zero forever
    a_extremes_bracket_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(r_lowest) <= 0) && ($signed(r_highest) >= 0))
        else $error("running extremes do not bracket zero");

    // plane result only shows up while the sequencer waits for it
    a_blend_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bl_done |-> (r_state == S_BWAIT))
        else $error("plane result arrived outside its wait state");

endmodule
